// ===== rtl/bsort_pkg.sv =====
// shared types and constants for the block sorter
`timescale 1ns / 1ps

package bsort_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_PLACE,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic rd_out;
    logic shift_wr;
    logic place_wr;
    logic out_load;
    logic out_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic less;
    logic pos_one;
    logic last_item;
    logic in_last;
    logic out_xfer;
    logic out_last;
  } sts_t;

endpackage

// ===== rtl/bsort_ctrl.sv =====
// controller state machine of the block sorter
`timescale 1ns / 1ps

module bsort_ctrl import bsort_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.full) begin
            // full store on a closing item goes straight to readout
            state_nxt = sts.in_last ? S_OUT_RD : S_IDLE;
          end else if (sts.empty) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.less && !sts.pos_one) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        state_nxt = sts.last_item ? S_OUT_RD : S_IDLE;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (sts.out_xfer) begin
          state_nxt = sts.out_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
      end
      S_CMP: begin
        cmd.shift_wr = sts.less;
      end
      S_PLACE: begin
        cmd.place_wr = 1'b1;
      end
      S_OUT_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_out = 1'b1;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
      end
      S_OUT_WAIT: begin
        cmd.out_adv = sts.out_xfer;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // only the idle state takes input
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE) else $error("input taken outside idle");

  // a shift only follows a compare that found the new value smaller
  a_shift_less: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> sts.less) else $error("shift without smaller value");

  // readout always follows a result load
  a_load_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == S_OUT_WAIT) else $error("load not followed by wait");

endmodule

// ===== rtl/bsort_dp.sv =====
// datapath of the block sorter: element store, insertion pointer, result register
`timescale 1ns / 1ps

module bsort_dp import bsort_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_last_out,
  output logic                     out_overflow
);

  logic [DATA_W-1:0]        mem [DEPTH];
  logic [DATA_W-1:0]        rd_data_r;
  logic signed [DATA_W-1:0] value_r;
  logic                     last_r;
  logic [ADDR_W-1:0]        pos_r;
  logic [CNT_W-1:0]         count_r;
  logic                     dropped_r;
  logic [ADDR_W-1:0]        k_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_value_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic                     full;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     out_xfer;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign out_xfer = out_valid_r && !out_stall;
  assign wr_en    = cmd.shift_wr || cmd.place_wr;
  assign wr_addr  = pos_r;
  assign wr_data  = cmd.shift_wr ? rd_data_r : value_r;
  assign rd_addr  = cmd.rd_out ? k_r : pos_r - ADDR_W'(1);

  // element store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // item capture and insertion pointer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r <= in_value;
      last_r  <= in_last_in;
      pos_r   <= count_r[ADDR_W-1:0];
    end else if (cmd.shift_wr) begin
      pos_r   <= pos_r - ADDR_W'(1);
    end
  end

  // block bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      k_r       <= '0;
    end else begin
      if (cmd.capture && full) begin
        dropped_r <= 1'b1;
      end
      if (cmd.place_wr) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.out_adv) begin
        if (out_last_r) begin
          count_r   <= '0;
          dropped_r <= 1'b0;
          k_r       <= '0;
        end else begin
          k_r <= k_r + ADDR_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= rd_data_r;
      out_last_r  <= ({1'b0, k_r} + CNT_W'(1)) == count_r;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  always_comb begin
    sts           = '0;
    sts.full      = full;
    sts.empty     = (count_r == '0);
    sts.less      = value_r < $signed(rd_data_r);
    sts.pos_one   = (pos_r == ADDR_W'(1));
    sts.last_item = last_r;
    sts.in_last   = in_last_in;
    sts.out_xfer  = out_xfer;
    sts.out_last  = out_last_r;
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("fill count beyond depth");

  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_wr |-> !full) else $error("insert into full store");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> count_r != '0) else $error("readout of empty store");

  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_adv && out_last_r) |=> (count_r == '0 && !dropped_r))
    else $error("block state not cleared after final transfer");

endmodule

// ===== rtl/block_sorter_core.sv =====
// top level of the block sorter
`timescale 1ns / 1ps

// block sorter: sorts a block of signed 32-bit values into ascending order
//
// input channel: in_valid / in_stall with in_value and in_last_in; a transfer
//   happens at a clock edge with in_valid high and in_stall low. in_last_in
//   closes the block. up to DEPTH (64) values are kept; later ones of the same
//   block are dropped and every result of that block shows out_overflow.
// result channel: out_valid / out_stall with out_sorted_value, out_last_out
//   and out_overflow, one transfer per stored value, smallest first, with
//   out_last_out on the final one.
// sorting: insertion sort into a single-port store; the walk reads and
//   compares one stored element at a time, top down, stopping at the first
//   one not larger; a value that meets a full store is dropped without a
//   walk. in_stall stays high until the item is placed.
// readout: each result is read, loaded into the output register and held
//   until transferred before the next is read; out_valid first rises after
//   the closing item is placed, or after it is taken when the store is full.
// stall: a held result stays in the output register until transferred;
//   no input is taken during readout.
// reset: rst_n (synchronous, active low) empties the store and clears the
//   overflow flag; no clearing pass, the store is only read after a write.

module block_sorter_core import bsort_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_last_out,
  output logic                     out_overflow
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of insertion and readout
  bsort_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, pointers and result register
  bsort_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule
